[hw/rtl/gost_pkg.sv]
// shared types, tables and round functions of the gost block cipher
package gost_pkg;

	localparam int unsigned BlkW = 128;
	localparam int unsigned KeyW = 64;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned NumRounds = 10;
	localparam int unsigned NumSteps = 32;

	typedef logic [BlkW-1:0] blk_t;
	typedef logic [7:0] byte_t;
	typedef logic [NumSteps-1:0][BlkW-1:0] ks_tab_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2,
		REG_KEY3 = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	localparam byte_t SBOX [256] = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
	};

	localparam byte_t SBOX_INV [256] = '{
		8'hA5,8'h2D,8'h32,8'h8F,8'h0E,8'h30,8'h38,8'hC0,8'h54,8'hE6,8'h9E,8'h39,8'h55,8'h7E,8'h52,8'h91,
		8'h64,8'h03,8'h57,8'h5A,8'h1C,8'h60,8'h07,8'h18,8'h21,8'h72,8'hA8,8'hD1,8'h29,8'hC6,8'hA4,8'h3F,
		8'hE0,8'h27,8'h8D,8'h0C,8'h82,8'hEA,8'hAE,8'hB4,8'h9A,8'h63,8'h49,8'hE5,8'h42,8'hE4,8'h15,8'hB7,
		8'hC8,8'h06,8'h70,8'h9D,8'h41,8'h75,8'h19,8'hC9,8'hAA,8'hFC,8'h4D,8'hBF,8'h2A,8'h73,8'h84,8'hD5,
		8'hC3,8'hAF,8'h2B,8'h86,8'hA7,8'hB1,8'hB2,8'h5B,8'h46,8'hD3,8'h9F,8'hFD,8'hD4,8'h0F,8'h9C,8'h2F,
		8'h9B,8'h43,8'hEF,8'hD9,8'h79,8'hB6,8'h53,8'h7F,8'hC1,8'hF0,8'h23,8'hE7,8'h25,8'h5E,8'hB5,8'h1E,
		8'hA2,8'hDF,8'hA6,8'hFE,8'hAC,8'h22,8'hF9,8'hE2,8'h4A,8'hBC,8'h35,8'hCA,8'hEE,8'h78,8'h05,8'h6B,
		8'h51,8'hE1,8'h59,8'hA3,8'hF2,8'h71,8'h56,8'h11,8'h6A,8'h89,8'h94,8'h65,8'h8C,8'hBB,8'h77,8'h3C,
		8'h7B,8'h28,8'hAB,8'hD2,8'h31,8'hDE,8'hC4,8'h5F,8'hCC,8'hCF,8'h76,8'h2C,8'hB8,8'hD8,8'h2E,8'h36,
		8'hDB,8'h69,8'hB3,8'h14,8'h95,8'hBE,8'h62,8'hA1,8'h3B,8'h16,8'h66,8'hE9,8'h5C,8'h6C,8'h6D,8'hAD,
		8'h37,8'h61,8'h4B,8'hB9,8'hE3,8'hBA,8'hF1,8'hA0,8'h85,8'h83,8'hDA,8'h47,8'hC5,8'hB0,8'h33,8'hFA,
		8'h96,8'h6F,8'h6E,8'hC2,8'hF6,8'h50,8'hFF,8'h5D,8'hA9,8'h8E,8'h17,8'h1B,8'h97,8'h7D,8'hEC,8'h58,
		8'hF7,8'h1F,8'hFB,8'h7C,8'h09,8'h0D,8'h7A,8'h67,8'h45,8'h87,8'hDC,8'hE8,8'h4F,8'h1D,8'h4E,8'h04,
		8'hEB,8'hF8,8'hF3,8'h3E,8'h3D,8'hBD,8'h8A,8'h88,8'hDD,8'hCD,8'h0B,8'h13,8'h98,8'h02,8'h93,8'h80,
		8'h90,8'hD0,8'h24,8'h34,8'hCB,8'hED,8'hF4,8'hCE,8'h99,8'h10,8'h44,8'h40,8'h92,8'h3A,8'h01,8'h26,
		8'h12,8'h1A,8'h48,8'h68,8'hF5,8'h81,8'h8B,8'hC7,8'hD6,8'h20,8'h0A,8'h08,8'h00,8'h4C,8'hD7,8'h74
	};

	localparam byte_t LIN_COEF [16] = '{
		8'h94,8'h20,8'h85,8'h10,8'hC2,8'hC0,8'h01,8'hFB,
		8'h01,8'hC0,8'hC2,8'h10,8'h85,8'h20,8'h94,8'h01
	};

	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t x;
		acc = '0;
		x = a;
		for (int n = 0; n < 8; n++) begin
			if (b[n]) acc = acc ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
		end
		return acc;
	endfunction

	function automatic blk_t lin_fwd(input blk_t d);
		byte_t v [16];
		byte_t acc;
		blk_t r;
		for (int k = 0; k < 16; k++) v[k] = d[8*k +: 8];
		for (int s = 0; s < 16; s++) begin
			acc = v[15];
			for (int i = 14; i >= 0; i--) begin
				v[i+1] = v[i];
				acc = acc ^ gf_mul(v[i], LIN_COEF[i]);
			end
			v[0] = acc;
		end
		for (int k = 0; k < 16; k++) r[8*k +: 8] = v[k];
		return r;
	endfunction

	function automatic blk_t lin_inv(input blk_t d);
		byte_t v [16];
		byte_t acc;
		blk_t r;
		for (int k = 0; k < 16; k++) v[k] = d[8*k +: 8];
		for (int s = 0; s < 16; s++) begin
			acc = v[0];
			for (int i = 0; i < 15; i++) begin
				v[i] = v[i+1];
				acc = acc ^ gf_mul(v[i], LIN_COEF[i]);
			end
			v[15] = acc;
		end
		for (int k = 0; k < 16; k++) r[8*k +: 8] = v[k];
		return r;
	endfunction

	function automatic blk_t sub_fwd(input blk_t d);
		blk_t r;
		for (int k = 0; k < 16; k++) r[8*k +: 8] = SBOX[d[8*k +: 8]];
		return r;
	endfunction

	function automatic blk_t sub_inv(input blk_t d);
		blk_t r;
		for (int k = 0; k < 16; k++) r[8*k +: 8] = SBOX_INV[d[8*k +: 8]];
		return r;
	endfunction

	// key schedule constants: entry i is L of byte 15 set to step i+1
	function automatic ks_tab_t make_ks_tab();
		ks_tab_t t;
		for (int i = 0; i < NumSteps; i++) t[i] = lin_fwd({8'(i + 1), 120'd0});
		return t;
	endfunction

	localparam ks_tab_t KS_CONST = make_ks_tab();

endpackage

[hw/rtl/gost_if.sv]
// handshake channel interfaces for blocks, results and configuration
interface gost_blk_if;
	logic valid;
	logic ready;
	logic op;
	logic [63:0] block_lo;
	logic [63:0] block_hi;
	modport source (output valid, op, block_lo, block_hi, input ready);
	modport sink (input valid, op, block_lo, block_hi, output ready);
endinterface

interface gost_res_if;
	logic valid;
	logic ready;
	logic [63:0] result_lo;
	logic [63:0] result_hi;
	modport source (output valid, result_lo, result_hi, input ready);
	modport sink (input valid, result_lo, result_hi, output ready);
endinterface

interface gost_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/gost_round.sv]
// shared round unit: key xor, s-box and linear layer in either direction
module gost_round (
	input gost_pkg::blk_t d,
	input gost_pkg::blk_t k,
	input logic inv,
	output gost_pkg::blk_t fwd_q_in,
	output gost_pkg::blk_t inv_out
);
	import gost_pkg::*;
	// forward: L(S(d ^ k)); inverse: S^-1(L^-1(d)) ^ k
	assign fwd_q_in = inv ? '0 : lin_fwd(sub_fwd(d ^ k));
	assign inv_out = inv ? (sub_inv(lin_inv(d)) ^ k) : '0;
endmodule

[hw/rtl/gost_top_dummy_unused.sv]
// key schedule round-key store
module gost_rkmem (
	input logic clk,
	input logic we,
	input logic [3:0] waddr,
	input gost_pkg::blk_t wdata,
	input logic [3:0] raddr,
	output gost_pkg::blk_t rdata
);
	import gost_pkg::*;
	blk_t mem [NumRounds];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end
	always_comb rdata = mem[raddr];
endmodule

[hw/rtl/gost_128bit_block_cipher_top.sv]
// gost 128-bit block cipher top level: key schedule, round sequencer and store
// A block is accepted while the core is idle and goes through one shared
// round unit (one round per cycle); the result is offered in the cycle after
// the final round key is applied and the core returns to idle once it is
// taken, so a new block is accepted only after the last result is taken.
// After any key register write, the next block first runs the key schedule:
// 32 Feistel steps through the same round unit, one per cycle, then the last
// round key pair is stored. Configuration writes are taken at any time but
// must only be issued while no block is in flight.
module gost_128bit_block_cipher_top (
	input logic clk,
	input logic arst_n,
	gost_cfg_if.sink cfg,
	gost_blk_if.sink in_ch,
	gost_res_if.source out_ch
);
	import gost_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEYS = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [KeyW-1:0] key_q [4];
	logic keys_ready_q;
	op_t op_q;
	blk_t data_q;
	blk_t ka_q, kb_q;
	logic [4:0] step_q;
	logic [3:0] rnd_q;

	blk_t rk_rdata;
	logic [3:0] rk_raddr;
	logic rk_we;
	logic [3:0] rk_waddr;
	blk_t rk_wdata;

	blk_t unit_d, unit_k, unit_f, unit_i;
	logic unit_inv;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.result_lo = data_q[63:0];
	assign out_ch.result_hi = data_q[127:64];

	gost_round u_round (
		.d(unit_d), .k(unit_k), .inv(unit_inv),
		.fwd_q_in(unit_f), .inv_out(unit_i)
	);

	gost_rkmem u_rk (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(rk_raddr), .rdata(rk_rdata)
	);

	// round keys 0 to 7 go out through kb_q: odd key after steps 0, 8, 16, 24,
	// even key one step later; after step 31, key 9 via kb_q, then key 8 via ka_q
	always_comb begin
		unit_inv = 1'b0;
		unit_d = data_q;
		unit_k = rk_rdata;
		rk_raddr = rnd_q;
		rk_we = 1'b0;
		rk_waddr = '0;
		rk_wdata = kb_q;
		if (state_q == ST_KEYS) begin
			unit_d = ka_q;
			unit_k = KS_CONST[step_q];
			if (rnd_q == 4'd1) begin
				rk_we = 1'b1;
				rk_waddr = 4'd9;
				rk_wdata = kb_q;
			end else if (rnd_q == 4'd2) begin
				rk_we = 1'b1;
				rk_waddr = 4'd8;
				rk_wdata = ka_q;
			end else if (step_q[2:1] == 2'b00) begin
				rk_we = 1'b1;
				rk_waddr = {1'b0, step_q[4:3], ~step_q[0]};
				rk_wdata = kb_q;
			end
		end else if (state_q == ST_RUN) begin
			unit_inv = (op_q == OP_DEC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keys_ready_q <= 1'b0;
			step_q <= '0;
			rnd_q <= '0;
			op_q <= OP_ENC;
			data_q <= '0;
			ka_q <= '0;
			kb_q <= '0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else begin
			if (cfg.valid) begin
				key_q[cfg.index] <= cfg.data;
				keys_ready_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						op_q <= op_t'(in_ch.op);
						data_q <= {in_ch.block_hi, in_ch.block_lo};
						if (!keys_ready_q) begin
							ka_q <= {key_q[1], key_q[0]};
							kb_q <= {key_q[3], key_q[2]};
							step_q <= '0;
							rnd_q <= '0;
							state_q <= ST_KEYS;
						end else begin
							rnd_q <= (op_t'(in_ch.op) == OP_DEC) ? 4'd9 : 4'd0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_KEYS: begin
					if (rnd_q == 4'd0) begin
						ka_q <= unit_f ^ kb_q;
						kb_q <= ka_q;
						if (step_q == 5'd31) rnd_q <= 4'd1;
						else step_q <= step_q + 5'd1;
					end else if (rnd_q == 4'd1) begin
						rnd_q <= 4'd2;
					end else begin
						keys_ready_q <= 1'b1;
						rnd_q <= (op_q == OP_DEC) ? 4'd9 : 4'd0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (op_q == OP_ENC) begin
						if (rnd_q == 4'd9) begin
							data_q <= data_q ^ rk_rdata;
							state_q <= ST_OUT;
						end else begin
							data_q <= unit_f;
							rnd_q <= rnd_q + 4'd1;
						end
					end else begin
						if (rnd_q == 4'd9) begin
							data_q <= data_q ^ rk_rdata;
							rnd_q <= 4'd8;
						end else begin
							data_q <= unit_i;
							if (rnd_q == 4'd0) state_q <= ST_OUT;
							else rnd_q <= rnd_q - 4'd1;
						end
					end
				end
				ST_OUT: begin
					if (out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> $stable(out_ch.result_lo))
		else $error("result changed while stalled");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
`endif
endmodule

[bench/gost_tb_if.sv]
// interface files come from the rtl; this file holds the bench's item record type
package gost_tb_pkg;
	import gost_pkg::*;

	typedef struct {
		op_t         op;
		logic [63:0] lo;
		logic [63:0] hi;
	} blk_row_t;
endpackage

[bench/gost_128bit_block_cipher_top_tb.sv]
// testbench for the gost 128-bit block cipher: directed table, then random blocks, keys and stalls
module gost_128bit_block_cipher_top_tb;
	import gost_pkg::*;
	import gost_tb_pkg::*;

	localparam int HoldCycles = 200;
	localparam int CycleLimit = 400000;
	localparam int NumRandom = 530;

	logic clk;
	logic arst_n;
	int cycles;
	int errors;
	bit hold_req;

	gost_cfg_if cfg ();
	gost_blk_if in_ch ();
	gost_res_if out_ch ();

	gost_128bit_block_cipher_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [63:0] key_regs [4];
	blk_t sched_keys [10];
	bit sched_valid;
	blk_t exp_blocks [$];

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void expand_schedule();
		blk_t a, b, c, t;
		a = {key_regs[1], key_regs[0]};
		b = {key_regs[3], key_regs[2]};
		sched_keys[0] = a;
		sched_keys[1] = b;
		for (int i = 1; i <= 32; i++) begin
			c = '0;
			c[127:120] = 8'(i);
			c = lin_fwd(c);
			t = lin_fwd(sub_fwd(a ^ c)) ^ b;
			b = a;
			a = t;
			if ((i % 8) == 0) begin
				sched_keys[i / 4] = a;
				sched_keys[i / 4 + 1] = b;
			end
		end
		sched_valid = 1'b1;
	endfunction

	function automatic blk_t cipher_block(op_t op, blk_t d);
		blk_t v;
		if (!sched_valid) expand_schedule();
		v = d;
		if (op == OP_ENC) begin
			for (int r = 0; r < 9; r++) v = lin_fwd(sub_fwd(v ^ sched_keys[r]));
			v = v ^ sched_keys[9];
		end else begin
			v = v ^ sched_keys[9];
			for (int r = 8; r >= 0; r--) v = sub_inv(lin_inv(v)) ^ sched_keys[r];
		end
		return v;
	endfunction

	// drives one write and leaves valid up for a following write
	task automatic put_key(reg_idx_t idx, logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		key_regs[idx] = value;
		sched_valid = 1'b0;
	endtask

	task automatic write_key(reg_idx_t idx, logic [63:0] value);
		put_key(idx, value);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (exp_blocks.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
		wait_drained();
		put_key(REG_KEY0, k0);
		put_key(REG_KEY1, k1);
		put_key(REG_KEY2, k2);
		put_key(REG_KEY3, k3);
		cfg.valid <= 1'b0;
	endtask

	// valid stays up after the item is taken until a gap before the next item, the next item or a drain
	task automatic send_block(op_t op, logic [63:0] lo, logic [63:0] hi, int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.block_lo <= lo;
		in_ch.block_hi <= hi;
		do @(posedge clk); while (!in_ch.ready);
		exp_blocks.push_back(cipher_block(op, {hi, lo}));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge64();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// result checking and receiver stalls
	initial begin
		blk_t want;
		int stall;
		out_ch.ready = 1'b0;
		errors = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 4) == 0) stall = 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (exp_blocks.size() == 0) begin
				$error("result_lo: unexpected result %h", out_ch.result_lo);
				errors++;
			end else begin
				want = exp_blocks.pop_front();
				if (out_ch.result_lo !== want[63:0]) begin
					$error("result_lo: expected %h actual %h", want[63:0], out_ch.result_lo);
					errors++;
				end
				if (out_ch.result_hi !== want[127:64]) begin
					$error("result_hi: expected %h actual %h", want[127:64], out_ch.result_hi);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		blk_row_t rows [$];
		blk_t got;
		cycles = 0;
		hold_req = 1'b0;
		sched_valid = 1'b0;
		for (int i = 0; i < 4; i++) key_regs[i] = '0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_KEY0;
		cfg.data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_ENC;
		in_ch.block_lo = '0;
		in_ch.block_hi = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero key after reset, then field extremes on both ops
		rows = '{
			'{OP_ENC, 64'h0, 64'h0},
			'{OP_DEC, 64'h0, 64'h0},
			'{OP_ENC, '1, '1},
			'{OP_DEC, '1, '1},
			'{OP_ENC, 64'h1, 64'h0},
			'{OP_DEC, 64'h0, 64'h8000000000000000},
			'{OP_ENC, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA},
			'{OP_DEC, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555}
		};
		foreach (rows[i]) send_block(rows[i].op, rows[i].lo, rows[i].hi, 0);

		// vector test: key 7766..88 ffee..88 efcd..01 1032..fe, block lo ffee..88 hi 7766..00
		set_key(64'h7766554433221188 ^ 64'h0 ^ 64'h0, 64'hFFEEDDCCBBAA9988 ^ 64'h0,
			64'hEFCDAB8967452301 ^ 64'h0, 64'h1032547698BADCFE);
		// check the round trip through the predictor
		send_block(OP_ENC, 64'hFFEEDDCCBBAA9988, 64'h7766554433221100, 0);
		got = cipher_block(OP_ENC, {64'h7766554433221100, 64'hFFEEDDCCBBAA9988});
		send_block(OP_DEC, got[63:0], got[127:64], 0);
		set_key('1, '1, '1, '1);
		send_block(OP_ENC, 64'h0, 64'h0, 0);
		send_block(OP_DEC, '1, '1, 0);
		// partial key update takes effect together
		wait_drained();
		write_key(REG_KEY2, 64'h0123456789ABCDEF);
		send_block(OP_ENC, 64'h1, 64'h2, 0);
		send_block(OP_DEC, 64'h3, 64'h4, 0);

		// receiver holds off while blocks keep coming
		wait_drained();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++) send_block(op_t'($urandom_range(0, 1)), rand64(), rand64(), 0);
		// sender pauses until all results are back
		wait_drained();

		for (int n = 0; n < NumRandom; n++) begin
			if ((n % 60) == 59) begin
				case ($urandom_range(0, 2))
					0: set_key(edge64(), edge64(), edge64(), edge64());
					1: set_key(rand64(), rand64(), rand64(), rand64());
					default: begin
						wait_drained();
						write_key(reg_idx_t'($urandom_range(0, 3)), edge64());
					end
				endcase
			end
			send_block(op_t'($urandom_range(0, 1)), edge64(), edge64(),
				(n % 100 < 20) ? 0 : $urandom_range(0, 11));
		end

		in_ch.valid <= 1'b0;
		while (exp_blocks.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
